// ===== src/dass_pkg.sv =====
// shared types and constants for the discrete affine state-space filter
// no dependencies; used by the interfaces, the row datapath and the top level

package dass_pkg;

    // field and register widths
    localparam int COEF_W    = 16;
    localparam int VAL_W     = 24;
    localparam int IN_W      = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // product and accumulator widths for one row (coef x state, coef x input)
    localparam int XPROD_W = COEF_W + VAL_W;
    localparam int UPROD_W = COEF_W + IN_W;
    localparam int ACC_W   = XPROD_W + 2;

    // default parameter values
    localparam int STATE_COUNT_DEF    = 2;
    localparam int INPUT_COUNT_DEF    = 1;
    localparam int COEF_FRAC_BITS_DEF = 13;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATE_MATRIX = 2'd0,
        CFG_INPUT_GAIN   = 2'd1,
        CFG_OUTPUT_GAIN  = 2'd2
    } t_cfg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [IN_W-1:0]   t_in;

    // signed 16-bit lane of a packed 64-bit register
    function automatic t_coef lane16(input logic [CFG_W-1:0] reg_value, input logic [1:0] lane);
        unique case (lane)
            2'd0: lane16 = t_coef'(reg_value[15:0]);
            2'd1: lane16 = t_coef'(reg_value[31:16]);
            2'd2: lane16 = t_coef'(reg_value[47:32]);
            2'd3: lane16 = t_coef'(reg_value[63:48]);
            default: lane16 = '0;
        endcase
    endfunction

endpackage

// ===== src/dass_if.sv =====
// valid/ready channel interfaces for the input and result streams
// depends on dass_pkg for field widths

interface dass_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [dass_pkg::IN_W-1:0] input_sample;

    modport source (output valid, output input_sample, input ready);
    modport sink   (input valid, input input_sample, output ready);
endinterface

interface dass_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [dass_pkg::VAL_W-1:0] output_sample;
    logic                            saturated;

    modport source (output valid, output output_sample, output saturated, input ready);
    modport sink   (input valid, input output_sample, input saturated, output ready);
endinterface

// ===== src/dass_row.sv =====
// one row of the state-space update: coef x state terms, coef x input, floor shift,
// integer offset and saturation to the 24-bit range; depends on dass_pkg

module dass_row #(
    parameter int FRAC_BITS = dass_pkg::COEF_FRAC_BITS_DEF,
    parameter bit USE_X1    = 1'b1
) (
    input  dass_pkg::t_coef i_coef_x0,
    input  dass_pkg::t_coef i_coef_x1,
    input  dass_pkg::t_coef i_coef_u,
    input  dass_pkg::t_coef i_offset,
    input  dass_pkg::t_val  i_x0,
    input  dass_pkg::t_val  i_x1,
    input  dass_pkg::t_in   i_u,
    output dass_pkg::t_val  o_value,
    output logic            o_clip
);

    localparam int ACC_W = dass_pkg::ACC_W;
    localparam logic signed [ACC_W:0] LIM_HI = (ACC_W+1)'((1 <<< (dass_pkg::VAL_W - 1)) - 1);
    localparam logic signed [ACC_W:0] LIM_LO = -LIM_HI - (ACC_W+1)'(1);

    logic signed [dass_pkg::XPROD_W-1:0] w_p0;
    logic signed [dass_pkg::XPROD_W-1:0] w_p1_full;
    logic signed [dass_pkg::XPROD_W-1:0] w_p1;
    logic signed [dass_pkg::UPROD_W-1:0] w_pu;
    logic signed [ACC_W-1:0]             w_sum;
    logic signed [ACC_W-1:0]             w_shift;
    logic signed [ACC_W:0]               w_total;

    // products
    assign w_p0      = i_coef_x0 * i_x0;
    assign w_p1_full = i_coef_x1 * i_x1;
    assign w_p1      = USE_X1 ? w_p1_full : '0;
    assign w_pu      = i_coef_u * i_u;

    // exact sum, floor shift, offset
    assign w_sum   = ACC_W'(w_p0) + ACC_W'(w_p1) + ACC_W'(w_pu);
    assign w_shift = w_sum >>> FRAC_BITS;
    assign w_total = (ACC_W+1)'(w_shift) + (ACC_W+1)'(i_offset);

    // clip to nearest bound
    always_comb begin
        if (w_total > LIM_HI) begin
            o_value = dass_pkg::t_val'(LIM_HI[dass_pkg::VAL_W-1:0]);
            o_clip  = 1'b1;
        end else if (w_total < LIM_LO) begin
            o_value = dass_pkg::t_val'(LIM_LO[dass_pkg::VAL_W-1:0]);
            o_clip  = 1'b1;
        end else begin
            o_value = dass_pkg::t_val'(w_total[dass_pkg::VAL_W-1:0]);
            o_clip  = 1'b0;
        end
    end

endmodule

// ===== src/discrete_affine_state_space_filter_top.sv =====
// top level of the discrete affine state-space filter: config registers, input and
// result registers, state registers and row datapaths; depends on dass_pkg, dass_if, dass_row
//
// usage:
//   i_in  : valid/ready stream of input samples u, one per sample period
//   o_out : valid/ready stream of results, output_sample y = C x + D u + y0 taken from the
//           state before the update, and saturated set when y or a new state was clipped
//   config: i_cfg_we/i_cfg_idx/i_cfg_data write one 64-bit register per cycle
//           (0 state matrix, 1 input gain and drift, 2 output gain and offset);
//           index 3 is ignored; write only while the stream is idle
// latency: a sample transferred at edge k is registered at once; its result is
//   computed in the next cycle and sits in the result register after edge k+1
// throughput: one sample per cycle; the state registers update in the same cycle
//   the result register loads, so the next sample sees the new state
// stall: when the receiver holds ready low the result register holds and one more
//   sample waits in the input register; after that ready goes low upstream
// reset: synchronous active low; clears state, config registers and valid flags

module discrete_affine_state_space_filter_top #(
    parameter int STATE_COUNT    = dass_pkg::STATE_COUNT_DEF,
    parameter int INPUT_COUNT    = dass_pkg::INPUT_COUNT_DEF,
    parameter int COEF_FRAC_BITS = dass_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dass_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dass_pkg::CFG_W-1:0]       i_cfg_data,
    dass_in_if.sink                          i_in,
    dass_out_if.source                       o_out
);

    localparam bit USE_X1 = (STATE_COUNT >= 2);

    logic [dass_pkg::CFG_W-1:0] r_state_matrix;
    logic [dass_pkg::CFG_W-1:0] r_input_gain;
    logic [dass_pkg::CFG_W-1:0] r_output_gain;

    logic           r_in_valid;
    dass_pkg::t_in  r_u;
    logic           r_out_valid;
    dass_pkg::t_val r_y;
    logic           r_sat;
    dass_pkg::t_val r_x0;
    dass_pkg::t_val w_x1;

    dass_pkg::t_in  w_u;
    logic           w_advance;
    logic           w_accept;
    dass_pkg::t_val w_y;
    dass_pkg::t_val w_nx0;
    dass_pkg::t_val w_nx1;
    logic           w_clip_y;
    logic           w_clip_x0;
    logic           w_clip_x1;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_matrix <= '0;
            r_input_gain   <= '0;
            r_output_gain  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dass_pkg::CFG_STATE_MATRIX: r_state_matrix <= i_cfg_data;
                dass_pkg::CFG_INPUT_GAIN:   r_input_gain   <= i_cfg_data;
                dass_pkg::CFG_OUTPUT_GAIN:  r_output_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake and pipeline advance
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_u         = (INPUT_COUNT > 0) ? r_u : '0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_u <= i_in.input_sample;
        end
    end

    // output row
    dass_row #(.FRAC_BITS(COEF_FRAC_BITS), .USE_X1(USE_X1)) u_row_y (
        .i_coef_x0 (dass_pkg::lane16(r_output_gain, 2'd0)),
        .i_coef_x1 (dass_pkg::lane16(r_output_gain, 2'd1)),
        .i_coef_u  (dass_pkg::lane16(r_output_gain, 2'd2)),
        .i_offset  (dass_pkg::lane16(r_output_gain, 2'd3)),
        .i_x0      (r_x0),
        .i_x1      (w_x1),
        .i_u       (w_u),
        .o_value   (w_y),
        .o_clip    (w_clip_y)
    );

    // first state row
    dass_row #(.FRAC_BITS(COEF_FRAC_BITS), .USE_X1(USE_X1)) u_row_x0 (
        .i_coef_x0 (dass_pkg::lane16(r_state_matrix, 2'd0)),
        .i_coef_x1 (dass_pkg::lane16(r_state_matrix, 2'd1)),
        .i_coef_u  (dass_pkg::lane16(r_input_gain, 2'd0)),
        .i_offset  (dass_pkg::lane16(r_input_gain, 2'd2)),
        .i_x0      (r_x0),
        .i_x1      (w_x1),
        .i_u       (w_u),
        .o_value   (w_nx0),
        .o_clip    (w_clip_x0)
    );

    // second state row and its register, only with two states
    generate
        if (STATE_COUNT >= 2) begin : g_x1
            dass_pkg::t_val r_x1;

            dass_row #(.FRAC_BITS(COEF_FRAC_BITS), .USE_X1(USE_X1)) u_row_x1 (
                .i_coef_x0 (dass_pkg::lane16(r_state_matrix, 2'd2)),
                .i_coef_x1 (dass_pkg::lane16(r_state_matrix, 2'd3)),
                .i_coef_u  (dass_pkg::lane16(r_input_gain, 2'd1)),
                .i_offset  (dass_pkg::lane16(r_input_gain, 2'd3)),
                .i_x0      (r_x0),
                .i_x1      (r_x1),
                .i_u       (w_u),
                .o_value   (w_nx1),
                .o_clip    (w_clip_x1)
            );

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_x1 <= '0;
                end else if (w_advance) begin
                    r_x1 <= w_nx1;
                end
            end

            assign w_x1 = r_x1;
        end else begin : g_no_x1
            assign w_nx1     = '0;
            assign w_clip_x1 = 1'b0;
            assign w_x1      = '0;
        end
    endgenerate

    // first state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0 <= '0;
        end else if (w_advance) begin
            r_x0 <= w_nx0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_y   <= w_y;
            r_sat <= w_clip_y | w_clip_x0 | w_clip_x1;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.output_sample = r_y;
    assign o_out.saturated     = r_sat;

    // a held sample blocks new transfers while the result register is stalled
    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input ready while held sample is stalled");

    // every advance leaves a result in the result register
    a_advance_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advance did not load the result register");

    // the first state register only moves with an advance
    a_state_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_advance && $past(i_rst_n)) |=> $stable(r_x0))
        else $error("state changed without an advance");

    // a stalled result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_advance)
        else $error("result register overwritten while stalled");

endmodule
